// ===== rtl/pictl_pkg.sv =====
// Shared widths, register indexes and stage types for the PI controller core.
package pictl_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = 17;
    localparam int DRIVE_W    = 16;
    localparam int INTEG_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int INT_LIM_W  = 31;
    localparam int OUT_LIM_W  = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // error times a gain, before the fractional shift
    localparam int PROD_W = ERR_W + GAIN_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd4;

    localparam logic MODE_CURRENT = 1'b0;
    localparam logic MODE_SPEED   = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [GAIN_W-1:0]    kp;
        logic [GAIN_W-1:0]    ki;
        logic [INT_LIM_W-1:0] int_limit;
        logic [OUT_LIM_W-1:0] out_limit;
    } t_cfg;

    // front end to integrator stage
    typedef struct packed {
        logic                     vld;
        logic signed [ERR_W-1:0]  err;
        logic signed [PROD_W-1:0] prop;
        logic signed [PROD_W-1:0] inc;
    } t_s2;

    // integrator stage to back end
    typedef struct packed {
        logic                      vld;
        logic signed [ERR_W-1:0]   err;
        logic signed [PROD_W-1:0]  prop;
        logic signed [INTEG_W-1:0] acc;
    } t_s3;

endpackage

// ===== rtl/pictl_if.sv =====
// Item channels of the PI controller core: sample input and drive result.
interface pictl_in_if;
    import pictl_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] target;
    logic signed [SAMPLE_W-1:0] measured;
    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pictl_out_if;
    import pictl_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   error;
    modport source (output valid, output drive, output error, input ready);
    modport sink   (input valid, input drive, input error, output ready);
endinterface

// ===== rtl/pi_controller_two_form_clamped_core.sv =====
// PI controller core with clamped integrator and two loop forms.
// Five register stages: input, error and products, integrator, integral term and result.
// Throughput: one item per cycle while no result waits; the integrator add and clamp is a one-stage recurrence.
// A waiting result stalls every stage and drops input ready until the result is taken.
// Reset (synchronous, active low) empties the pipeline, zeroes the integrator and
// loads the register defaults.
module pi_controller_two_form_clamped_core #(
    parameter int GAIN_FRAC_BITS = pictl_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pictl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pictl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pictl_in_if.sink                           i_req,
    pictl_out_if.source                        o_rsp
);
    import pictl_pkg::*;

    t_cfg w_cfg;
    t_s2  w_s2;
    t_s3  w_s3;
    logic w_en;
    logic w_vld;

    // advance everything unless a finished item is waiting
    assign w_en        = !w_vld || o_rsp.ready;
    assign i_req.ready = w_en;
    assign o_rsp.valid = w_vld;

    pictl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pictl_front #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_cfg      (w_cfg),
        .i_vld      (i_req.valid),
        .i_target   (i_req.target),
        .i_measured (i_req.measured),
        .o_s2       (w_s2)
    );

    pictl_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_s2    (w_s2),
        .o_s3    (w_s3)
    );

    pictl_back #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_s3    (w_s3),
        .o_vld   (w_vld),
        .o_drive (o_rsp.drive),
        .o_err   (o_rsp.error)
    );

endmodule

// ===== rtl/pictl_cfg.sv =====
// Configuration register file of the PI controller core.
module pictl_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pictl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pictl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pictl_pkg::t_cfg                    o_cfg
);
    import pictl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_CURRENT;
            r_cfg.kp        <= GAIN_W'(256);
            r_cfg.ki        <= '0;
            r_cfg.int_limit <= '0;
            r_cfg.out_limit <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:      r_cfg.mode      <= i_cfg_data[0];
                REG_KP:        r_cfg.kp        <= i_cfg_data[GAIN_W-1:0];
                REG_KI:        r_cfg.ki        <= i_cfg_data[GAIN_W-1:0];
                REG_INT_LIMIT: r_cfg.int_limit <= i_cfg_data[INT_LIM_W-1:0];
                REG_OUT_LIMIT: r_cfg.out_limit <= i_cfg_data[OUT_LIM_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pictl_front.sv =====
// Input register, error and the two error-times-gain products; in speed mode the increment is the error itself.
module pictl_front #(
    parameter int GAIN_FRAC_BITS = pictl_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  pictl_pkg::t_cfg                       i_cfg,
    input  logic                                  i_vld,
    input  logic signed [pictl_pkg::SAMPLE_W-1:0] i_target,
    input  logic signed [pictl_pkg::SAMPLE_W-1:0] i_measured,
    output pictl_pkg::t_s2                        o_s2
);
    import pictl_pkg::*;

    logic                       r_vld1;
    logic signed [SAMPLE_W-1:0] r_target;
    logic signed [SAMPLE_W-1:0] r_measured;

    logic                     r_vld2;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [PROD_W-1:0] r_prop;
    logic signed [PROD_W-1:0] r_inc;

    logic signed [ERR_W-1:0]  n_err;
    logic signed [PROD_W-1:0] n_prod_p;
    logic signed [PROD_W-1:0] n_prod_i;
    logic signed [PROD_W-1:0] n_prop;
    logic signed [PROD_W-1:0] n_inc;

    always_comb begin
        n_err    = {r_target[SAMPLE_W-1], r_target} - {r_measured[SAMPLE_W-1], r_measured};
        n_prod_p = n_err * $signed({1'b0, i_cfg.kp});
        n_prod_i = n_err * $signed({1'b0, i_cfg.ki});
        // arithmetic shift floors, as the gain format asks
        n_prop   = n_prod_p >>> GAIN_FRAC_BITS;
        if (i_cfg.mode == MODE_SPEED) begin
            n_inc = {{(PROD_W-ERR_W){n_err[ERR_W-1]}}, n_err};
        end else begin
            n_inc = n_prod_i >>> GAIN_FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_target   <= i_target;
            r_measured <= i_measured;
            r_err      <= n_err;
            r_prop     <= n_prop;
            r_inc      <= n_inc;
        end
    end

    assign o_s2 = '{vld: r_vld2, err: r_err, prop: r_prop, inc: r_inc};

endmodule

// ===== rtl/pictl_integ.sv =====
// Integrator register: add the increment and clamp to the integrator limit.
module pictl_integ (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  pictl_pkg::t_cfg i_cfg,
    input  pictl_pkg::t_s2  i_s2,
    output pictl_pkg::t_s3  o_s3
);
    import pictl_pkg::*;

    localparam int SUM_W = PROD_W + 1;

    logic signed [INTEG_W-1:0] r_integ;
    logic                      r_vld;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [PROD_W-1:0]  r_prop;

    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   n_lim;
    logic signed [INTEG_W-1:0] n_integ;

    always_comb begin
        n_sum = {{(SUM_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ}
              + {i_s2.inc[PROD_W-1], i_s2.inc};
        n_lim = $signed({{(SUM_W-INT_LIM_W){1'b0}}, i_cfg.int_limit});
        priority if (n_sum > n_lim) begin
            n_integ = n_lim[INTEG_W-1:0];
        end else if (n_sum < -n_lim) begin
            n_integ = INTEG_W'(-n_lim);
        end else begin
            n_integ = n_sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_s2.vld;
            // advance the integrator only on a real item
            if (i_s2.vld) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err  <= i_s2.err;
            r_prop <= i_s2.prop;
        end
    end

    assign o_s3 = '{vld: r_vld, err: r_err, prop: r_prop, acc: r_integ};

endmodule

// ===== rtl/pictl_back.sv =====
// Integral term scaling (speed mode only), drive sum, output clamp and result register.
module pictl_back #(
    parameter int GAIN_FRAC_BITS = pictl_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  pictl_pkg::t_cfg                      i_cfg,
    input  pictl_pkg::t_s3                       i_s3,
    output logic                                 o_vld,
    output logic signed [pictl_pkg::DRIVE_W-1:0] o_drive,
    output logic signed [pictl_pkg::ERR_W-1:0]   o_err
);
    import pictl_pkg::*;

    localparam int MUL_W = INTEG_W + GAIN_W + 1;
    localparam int SUM_W = MUL_W + 2;

    logic                     r_vld4;
    logic signed [MUL_W-1:0]  r_term;
    logic signed [PROD_W-1:0] r_prop;
    logic signed [ERR_W-1:0]  r_err4;

    logic                      r_vld5;
    logic signed [DRIVE_W-1:0] r_drive;
    logic signed [ERR_W-1:0]   r_err5;

    logic signed [MUL_W-1:0]   n_mul;
    logic signed [MUL_W-1:0]   n_term;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   n_lim;
    logic signed [DRIVE_W-1:0] n_drive;

    always_comb begin
        n_mul = i_s3.acc * $signed({1'b0, i_cfg.ki});
        if (i_cfg.mode == MODE_SPEED) begin
            n_term = n_mul >>> GAIN_FRAC_BITS;
        end else begin
            n_term = {{(MUL_W-INTEG_W){i_s3.acc[INTEG_W-1]}}, i_s3.acc};
        end
    end

    always_comb begin
        n_sum = {{(SUM_W-MUL_W){r_term[MUL_W-1]}}, r_term}
              + {{(SUM_W-PROD_W){r_prop[PROD_W-1]}}, r_prop};
        n_lim = $signed({{(SUM_W-OUT_LIM_W){1'b0}}, i_cfg.out_limit});
        priority if (n_sum > n_lim) begin
            n_drive = n_lim[DRIVE_W-1:0];
        end else if (n_sum < -n_lim) begin
            n_drive = DRIVE_W'(-n_lim);
        end else begin
            n_drive = n_sum[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (i_en) begin
            r_vld4 <= i_s3.vld;
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term  <= n_term;
            r_prop  <= i_s3.prop;
            r_err4  <= i_s3.err;
            r_drive <= n_drive;
            r_err5  <= r_err4;
        end
    end

    assign o_vld   = r_vld5;
    assign o_drive = r_drive;
    assign o_err   = r_err5;

endmodule

// ===== rtl/pictl_chk.sv =====
// Port-level checks for the PI controller core, bound to the top level.
module pictl_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [pictl_pkg::DRIVE_W-1:0]  i_drive
);
    import pictl_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // the symmetric clamp never yields the most negative code
    a_drive_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_drive != {1'b1, {(DRIVE_W-1){1'b0}}})
        else $error("drive outside symmetric clamp");

    // a waiting result stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive))
        else $error("stalled result dropped or changed");

endmodule

bind pi_controller_two_form_clamped_core pictl_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_drive     (o_rsp.drive)
);
